// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the core RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_ALWAYS(label, clk, rst_n, expr)

`endif

`endif

// ----- rtl/core/uvcpfa_pkg.sv -----
package uvcpfa_pkg;

    localparam int FRAME_BYTES  = 131072;
    localparam int MAX_PACKET   = 1024;
    localparam int HEADER_BYTES = 12;

    localparam int SIZE_W = $clog2(MAX_PACKET + 1);
    localparam int POS_W  = $clog2(MAX_PACKET);
    localparam int LEN_W  = $clog2(FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(FRAME_BYTES);

    localparam int FLAG_TOGGLE_BIT = 0;
    localparam int FLAG_END_BIT    = 1;
    localparam int FLAG_ERROR_BIT  = 6;

    localparam logic [15:0] MARK_SOI = 16'hFFD8;
    localparam logic [15:0] MARK_EOI = 16'hFFD9;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_DELIVERED = 2'd1,
        EV_DROPPED   = 2'd2,
        EV_BAD_FRAME = 2'd3
    } frame_event_t;

endpackage

// ----- rtl/core/uvc_payload_frame_assembler.sv -----
// The result of an input transfer is registered on the output register in the cycle after it.
// Throughput: one byte per cycle while out_ready holds; the output register frees in the same cycle it is taken.
// The header, fit and marker checks run in one pass between the state and result registers.
// Reset (rst_n low, asynchronous): output empty, frame state cleared, frame open,
// previous packet marked as end of frame, mjpeg_mode cleared.
`include "assert_macros.svh"

module uvc_payload_frame_assembler (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          data_byte,
    input  logic [uvcpfa_pkg::SIZE_W-1:0]       packet_size,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                write_valid,
    output logic                                write_buffer,
    output logic [uvcpfa_pkg::ADDR_W-1:0]       write_address,
    output logic [7:0]                          write_data,
    output uvcpfa_pkg::frame_event_t            frame_event,
    output logic [uvcpfa_pkg::LEN_W-1:0]        frame_length,
    output logic                                frame_buffer
);
    import uvcpfa_pkg::*;

    logic                 mjpeg_mode_reg;
    logic [POS_W-1:0]     byte_position_reg,   byte_position_next;
    logic [7:0]           header_flags_reg,    header_flags_next;
    logic                 previous_toggle_reg, previous_toggle_next;
    logic                 previous_end_reg,    previous_end_next;
    logic                 frame_started_reg,   frame_started_next;
    logic                 error_seen_reg,      error_seen_next;
    logic [LEN_W-1:0]     bytes_in_frame_reg,  bytes_in_frame_next;
    logic                 active_buffer_reg,   active_buffer_next;
    logic                 packet_fits_reg,     packet_fits_next;
    logic [15:0]          first_two_reg,       first_two_next;
    logic [15:0]          last_two_reg,        last_two_next;

    logic                 out_valid_reg;
    logic                 write_valid_reg,     write_valid_next;
    logic                 write_buffer_reg,    write_buffer_next;
    logic [ADDR_W-1:0]    write_address_reg,   write_address_next;
    logic [7:0]           write_data_reg,      write_data_next;
    frame_event_t         frame_event_reg,     frame_event_next;
    logic [LEN_W-1:0]     frame_length_reg,    frame_length_next;
    logic                 frame_buffer_reg,    frame_buffer_next;

    logic                 in_xfer;
    logic [SIZE_W-1:0]    size_c;
    logic                 big;
    logic [LEN_W:0]       fit_sum;
    logic                 store;
    logic                 last_byte;
    logic                 frame_ok;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_xfer   = in_valid && in_ready;

    always_comb
    begin
        if (packet_size == '0)
            size_c = SIZE_W'(1);
        else if (packet_size > SIZE_W'(MAX_PACKET))
            size_c = SIZE_W'(MAX_PACKET);
        else
            size_c = packet_size;
        big = size_c > SIZE_W'(HEADER_BYTES);

        header_flags_next    = header_flags_reg;
        previous_toggle_next = previous_toggle_reg;
        previous_end_next    = previous_end_reg;
        frame_started_next   = frame_started_reg;
        error_seen_next      = error_seen_reg;
        bytes_in_frame_next  = bytes_in_frame_reg;
        active_buffer_next   = active_buffer_reg;
        packet_fits_next     = packet_fits_reg;
        first_two_next       = first_two_reg;
        last_two_next        = last_two_reg;
        fit_sum              = '0;
        frame_ok             = 1'b0;

        write_valid_next   = 1'b0;
        write_buffer_next  = 1'b0;
        write_address_next = '0;
        write_data_next    = '0;
        frame_event_next   = EV_NONE;
        frame_length_next  = '0;
        frame_buffer_next  = 1'b0;

        // capture header flags and decide start, error and fit
        if (byte_position_reg == POS_W'(1))
        begin
            header_flags_next = data_byte;
            if (big)
            begin
                if ((data_byte[FLAG_TOGGLE_BIT] != previous_toggle_reg) && previous_end_reg)
                begin
                    bytes_in_frame_next = '0;
                    error_seen_next     = 1'b0;
                    frame_started_next  = 1'b1;
                end
                previous_toggle_next = data_byte[FLAG_TOGGLE_BIT];
                if (data_byte[FLAG_ERROR_BIT])
                    error_seen_next = 1'b1;
                fit_sum = {1'b0, bytes_in_frame_next}
                        + (LEN_W+1)'(size_c - SIZE_W'(HEADER_BYTES));
                if (fit_sum > (LEN_W+1)'(FRAME_BYTES))
                begin
                    bytes_in_frame_next = LEN_W'(FRAME_BYTES);
                    packet_fits_next    = 1'b0;
                end
                else
                    packet_fits_next = 1'b1;
            end
            else
                packet_fits_next = 1'b0;
        end

        store = big && (byte_position_reg >= POS_W'(HEADER_BYTES)) && packet_fits_next
             && (bytes_in_frame_next < LEN_W'(FRAME_BYTES));

        if (store)
        begin
            write_valid_next   = 1'b1;
            write_buffer_next  = active_buffer_reg;
            write_address_next = bytes_in_frame_next[ADDR_W-1:0];
            write_data_next    = data_byte;
            if (bytes_in_frame_next == LEN_W'(0))
                first_two_next[15:8] = data_byte;
            else if (bytes_in_frame_next == LEN_W'(1))
                first_two_next[7:0] = data_byte;
            last_two_next       = {last_two_reg[7:0], data_byte};
            bytes_in_frame_next = bytes_in_frame_next + LEN_W'(1);
        end

        last_byte = ({1'b0, byte_position_reg} + (POS_W+1)'(1)) >= (POS_W+1)'(size_c);

        if (last_byte)
        begin
            byte_position_next = '0;
            if (big)
            begin
                if (header_flags_next[FLAG_END_BIT])
                begin
                    previous_end_next = 1'b1;
                    if (!frame_started_next)
                    begin
                        frame_event_next    = EV_BAD_FRAME;
                        frame_length_next   = bytes_in_frame_next;
                        frame_buffer_next   = active_buffer_reg;
                        bytes_in_frame_next = '0;
                    end
                    else if (mjpeg_mode_reg)
                    begin
                        frame_ok = !error_seen_next && packet_fits_next
                                && (bytes_in_frame_next >= LEN_W'(2))
                                && (first_two_next == MARK_SOI)
                                && (last_two_next == MARK_EOI);
                        frame_event_next    = frame_ok ? EV_DELIVERED : EV_DROPPED;
                        frame_length_next   = bytes_in_frame_next;
                        frame_buffer_next   = active_buffer_reg;
                        active_buffer_next  = !active_buffer_reg;
                        frame_started_next  = 1'b0;
                        bytes_in_frame_next = '0;
                    end
                end
                else
                    previous_end_next = 1'b0;
            end
        end
        else
            byte_position_next = byte_position_reg + POS_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mjpeg_mode_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            mjpeg_mode_reg <= cfg_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg   <= '0;
            header_flags_reg    <= '0;
            previous_toggle_reg <= 1'b0;
            previous_end_reg    <= 1'b1;
            frame_started_reg   <= 1'b1;
            error_seen_reg      <= 1'b0;
            bytes_in_frame_reg  <= '0;
            active_buffer_reg   <= 1'b0;
            packet_fits_reg     <= 1'b0;
            first_two_reg       <= '0;
            last_two_reg        <= '0;
        end
        else if (in_xfer)
        begin
            byte_position_reg   <= byte_position_next;
            header_flags_reg    <= header_flags_next;
            previous_toggle_reg <= previous_toggle_next;
            previous_end_reg    <= previous_end_next;
            frame_started_reg   <= frame_started_next;
            error_seen_reg      <= error_seen_next;
            bytes_in_frame_reg  <= bytes_in_frame_next;
            active_buffer_reg   <= active_buffer_next;
            packet_fits_reg     <= packet_fits_next;
            first_two_reg       <= first_two_next;
            last_two_reg        <= last_two_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_xfer)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // hold result until the downstream transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            write_valid_reg   <= write_valid_next;
            write_buffer_reg  <= write_buffer_next;
            write_address_reg <= write_address_next;
            write_data_reg    <= write_data_next;
            frame_event_reg   <= frame_event_next;
            frame_length_reg  <= frame_length_next;
            frame_buffer_reg  <= frame_buffer_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_valid   = write_valid_reg;
    assign write_buffer  = write_buffer_reg;
    assign write_address = write_address_reg;
    assign write_data    = write_data_reg;
    assign frame_event   = frame_event_reg;
    assign frame_length  = frame_length_reg;
    assign frame_buffer  = frame_buffer_reg;

    `ASSERT_ALWAYS(a_len_range, clk, rst_n, bytes_in_frame_reg <= LEN_W'(FRAME_BYTES))
    `ASSERT_IMPLIES(a_event_clears_len, clk, rst_n,
        out_valid_reg && (frame_event_reg != EV_NONE), bytes_in_frame_reg == '0)
    `ASSERT_IMPLIES(a_swap_on_mjpeg_end, clk, rst_n,
        out_valid_reg && ((frame_event_reg == EV_DELIVERED) || (frame_event_reg == EV_DROPPED)),
        active_buffer_reg != frame_buffer_reg)
    `ASSERT_IMPLIES(a_len_follows_write, clk, rst_n,
        out_valid_reg && write_valid_reg && (frame_event_reg == EV_NONE),
        bytes_in_frame_reg == ({1'b0, write_address_reg} + LEN_W'(1)))

endmodule
